>>> rtl/bba_pkg.sv
// Shared types and constants for the block bitmap allocator.
// No dependencies; every other file in rtl/ but bba_map_mem refers to it by scoped names.
package bba_pkg;

    localparam int WORD_BITS = 64;
    localparam int BIT_W     = 6;

    typedef enum logic [1:0] {
        STAT_OK      = 2'd0,
        STAT_NOSPACE = 2'd1,
        STAT_RANGE   = 2'd2,
        STAT_FREE    = 2'd3
    } status_t;

    typedef enum logic [1:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_ALLOC,
        ST_FREE
    } state_t;

    typedef struct packed {
        logic        mode;
        logic [6:0]  count;
        logic [13:0] block_addr;
    } request_t;

    typedef struct packed {
        logic [13:0] block_number;
        status_t     status;
        logic        last;
        logic [14:0] occupied;
    } result_t;

endpackage

>>> rtl/block_bitmap_allocator.sv
// Top level of the block bitmap allocator: sequencer, used-map memory, result register.
// Uses bba_pkg, bba_ctrl and bba_map_mem.
//
//   channel   ports                        handshake
//   request   start, busy, request         taken when start is high and busy low
//   result    result_valid, result         one cycle per result, cannot be held off
//
// Allocate: the request is taken and the lowest map word not known to be full is read;
// then the scan either hands out one block from the current word or retires a full word
// and reads the next one (64 blocks per word, one word read per step from the map memory).
// Free requests give their single result once the map word is read, error requests
// straight from the idle state. After reset a clearing pass writes every map word once
// with busy high. Results leave through a register; the receiver has no stall.
module block_bitmap_allocator #(
    parameter int NUM_BLOCKS      = 16384,
    parameter int RESERVED_BLOCKS = 64,
    parameter int MAX_RUN         = 64
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    input  bba_pkg::request_t request,
    output logic              busy,
    output logic              result_valid,
    output bba_pkg::result_t  result
);

    localparam int NUM_WORDS = (NUM_BLOCKS + bba_pkg::WORD_BITS - 1) / bba_pkg::WORD_BITS;
    localparam int WIDX_W    = (NUM_WORDS > 1) ? $clog2(NUM_WORDS) : 1;

    logic                          wr_en;
    logic [WIDX_W-1:0]             wr_addr;
    logic [bba_pkg::WORD_BITS-1:0] wr_data;
    logic                          rd_en;
    logic [WIDX_W-1:0]             rd_addr;
    logic [bba_pkg::WORD_BITS-1:0] rd_data;
    logic                          res_valid;
    bba_pkg::result_t              res;
    logic                          result_valid_reg;
    bba_pkg::result_t              result_reg;

    bba_ctrl #(
        .NUM_BLOCKS      (NUM_BLOCKS),
        .RESERVED_BLOCKS (RESERVED_BLOCKS),
        .MAX_RUN         (MAX_RUN),
        .NUM_WORDS       (NUM_WORDS),
        .WIDX_W          (WIDX_W)
    ) u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .request   (request),
        .busy      (busy),
        .wr_en     (wr_en),
        .wr_addr   (wr_addr),
        .wr_data   (wr_data),
        .rd_en     (rd_en),
        .rd_addr   (rd_addr),
        .rd_data   (rd_data),
        .res_valid (res_valid),
        .res       (res)
    );

    bba_map_mem #(
        .WORDS  (NUM_WORDS),
        .ADDR_W (WIDX_W),
        .DATA_W (bba_pkg::WORD_BITS)
    ) u_map_mem (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            result_valid_reg <= 1'b0;
        end
        else
        begin
            result_valid_reg <= res_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        result_reg <= res;
    end

    assign result_valid = result_valid_reg;
    assign result       = result_reg;

endmodule

>>> rtl/bba_map_mem.sv
// Used-map storage: one write port, one read port, registered read data.
// Depends on nothing; the top level sizes it through parameters.
module bba_map_mem #(
    parameter int WORDS  = 256,
    parameter int ADDR_W = 8,
    parameter int DATA_W = 64
) (
    input  logic              clk,
    input  logic              wr_en,
    input  logic [ADDR_W-1:0] wr_addr,
    input  logic [DATA_W-1:0] wr_data,
    input  logic              rd_en,
    input  logic [ADDR_W-1:0] rd_addr,
    output logic [DATA_W-1:0] rd_data
);

    logic [DATA_W-1:0] mem [WORDS];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

>>> rtl/bba_first_zero.sv
// Lowest clear bit of one used-map word.
// Uses bba_pkg for the word width.
module bba_first_zero (
    input  logic [bba_pkg::WORD_BITS-1:0] word,
    output logic                          found,
    output logic [bba_pkg::BIT_W-1:0]     idx
);

    always_comb
    begin
        found = 1'b0;
        idx   = '0;
        // scan from the top so the lowest clear bit wins
        for (int j = bba_pkg::WORD_BITS - 1; j >= 0; j--)
        begin
            if (!word[j])
            begin
                found = 1'b1;
                idx   = bba_pkg::BIT_W'(j);
            end
        end
    end

endmodule

>>> rtl/bba_ctrl.sv
// Allocator sequencer: clearing pass, word scan, free check, occupied count.
// Uses bba_pkg and bba_first_zero; drives the ports of bba_map_mem.
module bba_ctrl #(
    parameter int NUM_BLOCKS      = 16384,
    parameter int RESERVED_BLOCKS = 64,
    parameter int MAX_RUN         = 64,
    parameter int NUM_WORDS       = 256,
    parameter int WIDX_W          = 8
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    input  bba_pkg::request_t             request,
    output logic                          busy,
    output logic                          wr_en,
    output logic [WIDX_W-1:0]             wr_addr,
    output logic [bba_pkg::WORD_BITS-1:0] wr_data,
    output logic                          rd_en,
    output logic [WIDX_W-1:0]             rd_addr,
    input  logic [bba_pkg::WORD_BITS-1:0] rd_data,
    output logic                          res_valid,
    output bba_pkg::result_t              res
);

    localparam int WB      = bba_pkg::WORD_BITS;
    localparam int BW      = bba_pkg::BIT_W;
    localparam int RES_EFF = (RESERVED_BLOCKS > NUM_BLOCKS) ? NUM_BLOCKS : RESERVED_BLOCKS;
    localparam int OCC_W   = $clog2(NUM_BLOCKS + 1);
    localparam int POS_W   = WIDX_W + BW + 1;
    localparam int LOW_RST = (RES_EFF / WB > NUM_WORDS - 1) ? NUM_WORDS - 1 : RES_EFF / WB;

    bba_pkg::state_t   state_reg, state_next;
    logic [OCC_W-1:0]  occ_reg, occ_next;
    logic [WIDX_W-1:0] low_reg, low_next;
    logic [WIDX_W-1:0] widx_reg, widx_next;
    logic [WIDX_W-1:0] clr_reg, clr_next;
    logic [6:0]        rem_reg, rem_next;
    logic [WB-1:0]     cur_word_reg, cur_word_next;
    logic              fresh_reg, fresh_next;
    logic [BW-1:0]     bit_reg, bit_next;

    logic [WB-1:0]     word;
    logic [WB-1:0]     word_mod;
    logic [WB-1:0]     init_word;
    logic              zero_found;
    logic [BW-1:0]     zero_idx;
    logic              accept;
    logic              free_bad;
    logic              alloc_bad;
    logic              go_free;
    logic              go_alloc;
    logic              clr_done;
    logic              alloc_done;
    logic [WIDX_W-1:0] free_widx;
    logic [OCC_W-1:0]  occ_inc;
    logic [OCC_W-1:0]  occ_dec;

    assign word     = fresh_reg ? rd_data : cur_word_reg;
    assign word_mod = word | (WB'(1) << zero_idx);
    assign occ_inc  = occ_reg + OCC_W'(1);
    assign occ_dec  = occ_reg - OCC_W'(1);

    bba_first_zero u_first_zero (
        .word  (word),
        .found (zero_found),
        .idx   (zero_idx)
    );

    // reserved blocks and positions past the end of the map start out used
    always_comb
    begin
        for (int j = 0; j < WB; j++)
        begin
            init_word[j] = ({1'b0, clr_reg, BW'(j)} < POS_W'(RES_EFF))
                        || ({1'b0, clr_reg, BW'(j)} >= POS_W'(NUM_BLOCKS));
        end
    end

    assign busy      = (state_reg != bba_pkg::ST_IDLE);
    assign accept    = start && !busy;
    assign free_bad  = (32'(request.block_addr) < 32'(RES_EFF))
                    || (32'(request.block_addr) >= 32'(NUM_BLOCKS));
    assign alloc_bad = (request.count > 7'(MAX_RUN))
                    || (({1'b0, occ_reg} + (OCC_W + 1)'(request.count))
                        > (OCC_W + 1)'(NUM_BLOCKS));
    assign go_free   = accept && request.mode && !free_bad;
    assign go_alloc  = accept && !request.mode && (request.count != 7'd0) && !alloc_bad;
    assign free_widx = WIDX_W'(request.block_addr >> BW);
    assign clr_done  = (clr_reg == WIDX_W'(NUM_WORDS - 1));
    assign alloc_done = zero_found && (rem_reg == 7'd1);

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            bba_pkg::ST_CLEAR:
            begin
                if (clr_done)
                begin
                    state_next = bba_pkg::ST_IDLE;
                end
            end
            bba_pkg::ST_IDLE:
            begin
                if (go_free)
                begin
                    state_next = bba_pkg::ST_FREE;
                end
                else if (go_alloc)
                begin
                    state_next = bba_pkg::ST_ALLOC;
                end
            end
            bba_pkg::ST_ALLOC:
            begin
                if (alloc_done)
                begin
                    state_next = bba_pkg::ST_IDLE;
                end
            end
            bba_pkg::ST_FREE:
            begin
                state_next = bba_pkg::ST_IDLE;
            end
            default:
            begin
                state_next = bba_pkg::ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        occ_next      = occ_reg;
        low_next      = low_reg;
        widx_next     = widx_reg;
        clr_next      = clr_reg;
        rem_next      = rem_reg;
        cur_word_next = cur_word_reg;
        fresh_next    = fresh_reg;
        bit_next      = bit_reg;
        wr_en         = 1'b0;
        wr_addr       = widx_reg;
        wr_data       = word;
        rd_en         = 1'b0;
        rd_addr       = low_reg;
        res_valid     = 1'b0;
        res           = '0;
        res.occupied  = 15'(occ_reg);
        res.last      = 1'b1;
        res.status    = bba_pkg::STAT_OK;
        case (state_reg)
            bba_pkg::ST_CLEAR:
            begin
                wr_en    = 1'b1;
                wr_addr  = clr_reg;
                wr_data  = init_word;
                clr_next = clr_reg + WIDX_W'(1);
            end
            bba_pkg::ST_IDLE:
            begin
                if (accept && request.mode)
                begin
                    if (free_bad)
                    begin
                        res_valid  = 1'b1;
                        res.status = bba_pkg::STAT_RANGE;
                    end
                    else
                    begin
                        rd_en     = 1'b1;
                        rd_addr   = free_widx;
                        widx_next = free_widx;
                        bit_next  = request.block_addr[BW-1:0];
                    end
                end
                else if (accept && (request.count != 7'd0))
                begin
                    if (alloc_bad)
                    begin
                        res_valid  = 1'b1;
                        res.status = bba_pkg::STAT_NOSPACE;
                    end
                    else
                    begin
                        rd_en      = 1'b1;
                        rd_addr    = low_reg;
                        widx_next  = low_reg;
                        rem_next   = request.count;
                        fresh_next = 1'b1;
                    end
                end
            end
            bba_pkg::ST_ALLOC:
            begin
                fresh_next = 1'b0;
                if (zero_found)
                begin
                    cur_word_next    = word_mod;
                    occ_next         = occ_inc;
                    rem_next         = rem_reg - 7'd1;
                    res_valid        = 1'b1;
                    res.block_number = 14'({widx_reg, zero_idx});
                    res.last         = (rem_reg == 7'd1);
                    res.occupied     = 15'(occ_inc);
                    if (rem_reg == 7'd1)
                    begin
                        // write back the last touched word; all below it are full
                        wr_en    = 1'b1;
                        wr_data  = word_mod;
                        low_next = widx_reg;
                    end
                end
                else
                begin
                    // word is full: retire it and fetch the next one
                    wr_en      = 1'b1;
                    wr_data    = word;
                    widx_next  = widx_reg + WIDX_W'(1);
                    rd_en      = 1'b1;
                    rd_addr    = widx_reg + WIDX_W'(1);
                    fresh_next = 1'b1;
                end
            end
            bba_pkg::ST_FREE:
            begin
                res_valid = 1'b1;
                if (!rd_data[bit_reg])
                begin
                    res.status = bba_pkg::STAT_FREE;
                end
                else
                begin
                    wr_en        = 1'b1;
                    wr_data      = rd_data & ~(WB'(1) << bit_reg);
                    occ_next     = occ_dec;
                    res.occupied = 15'(occ_dec);
                    if (widx_reg < low_reg)
                    begin
                        low_next = widx_reg;
                    end
                end
            end
            default:
            begin
                res_valid = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= bba_pkg::ST_CLEAR;
            occ_reg   <= OCC_W'(RES_EFF);
            low_reg   <= WIDX_W'(LOW_RST);
            clr_reg   <= '0;
            rem_reg   <= '0;
            fresh_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            occ_reg   <= occ_next;
            low_reg   <= low_next;
            clr_reg   <= clr_next;
            rem_reg   <= rem_next;
            fresh_reg <= fresh_next;
        end
    end

    always_ff @(posedge clk)
    begin
        widx_reg     <= widx_next;
        cur_word_reg <= cur_word_next;
        bit_reg      <= bit_next;
    end

`ifndef SYNTHESIS
    a_err_is_last: assert property (@(posedge clk) disable iff (!rst_n)
        (res_valid && (res.status != bba_pkg::STAT_OK)) |-> res.last)
        else $error("error result without last");

    a_occ_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (32'(occ_reg) <= 32'(NUM_BLOCKS)))
        else $error("occupied count beyond capacity");

    a_no_rw_clash: assert property (@(posedge clk) disable iff (!rst_n)
        !(wr_en && rd_en && (wr_addr == rd_addr)))
        else $error("read and write of the same word in one cycle");

    a_alloc_rem: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == bba_pkg::ST_ALLOC) |-> (rem_reg != 7'd0))
        else $error("scan running with nothing left to allocate");

    a_free_read: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != bba_pkg::ST_FREE) ##1 (state_reg == bba_pkg::ST_FREE)
        |-> $past(rd_en))
        else $error("free check without a word read");
`endif

endmodule

>>> tb/tb_block_bitmap_allocator.sv
// Self-checking testbench for block_bitmap_allocator: directed and random allocate/free
// requests, with an in-bench first-fit model of the used map checking every result.
// Depends on rtl/bba_pkg.sv and rtl/block_bitmap_allocator.sv.
module tb_block_bitmap_allocator;

    localparam int NUM_BLOCKS      = 16384;
    localparam int RESERVED_BLOCKS = 64;
    localparam int MAX_RUN         = 64;
    localparam int CYCLE_LIMIT     = 2000000;
    localparam int DRAIN_CYCLES    = 300;

    localparam logic MODE_ALLOC = 1'b0;
    localparam logic MODE_FREE  = 1'b1;

    // Mirror of the used map and occupied count; predicts the blocks each request hands out.
    class alloc_scoreboard;
        bit                        used [NUM_BLOCKS];
        int                        occupied;
        int                        top_block;
        int                        errors;
        bba_pkg::result_t          pending_replies[$];

        function new();
            for (int b = 0; b < NUM_BLOCKS; b++)
                used[b] = (b < RESERVED_BLOCKS);
            occupied  = RESERVED_BLOCKS;
            top_block = RESERVED_BLOCKS;
            errors    = 0;
        endfunction

        function void push_reply(int blk, bba_pkg::status_t st, logic lst);
            bba_pkg::result_t r;
            r.block_number  = blk[13:0];
            r.status        = st;
            r.last          = lst;
            r.occupied      = occupied[14:0];
            pending_replies = {pending_replies, r};
        endfunction

        function void note_request(bba_pkg::request_t req);
            int addr;
            int n;
            int k;
            addr = req.block_addr;
            n    = req.count;
            k    = 0;
            if (req.mode == MODE_FREE)
            begin
                if (addr < RESERVED_BLOCKS || addr >= NUM_BLOCKS)
                    push_reply(0, bba_pkg::STAT_RANGE, 1'b1);
                else if (!used[addr])
                    push_reply(0, bba_pkg::STAT_FREE, 1'b1);
                else
                begin
                    used[addr] = 1'b0;
                    occupied--;
                    push_reply(0, bba_pkg::STAT_OK, 1'b1);
                end
                return;
            end
            // zero count: no reply at all
            if (n == 0)
                return;
            if (n > MAX_RUN || occupied + n > NUM_BLOCKS)
            begin
                push_reply(0, bba_pkg::STAT_NOSPACE, 1'b1);
                return;
            end
            for (int b = RESERVED_BLOCKS; b < NUM_BLOCKS && k < n; b++)
            begin
                if (!used[b])
                begin
                    used[b] = 1'b1;
                    occupied++;
                    k++;
                    if (b > top_block)
                        top_block = b;
                    push_reply(b, bba_pkg::STAT_OK, k == n);
                end
            end
        endfunction

        function void check_result(bba_pkg::result_t got);
            bba_pkg::result_t want;
            if (pending_replies.size() == 0)
            begin
                $error("unexpected result: block_number %0d status %0d last %0d occupied %0d",
                       got.block_number, got.status, got.last, got.occupied);
                errors++;
                return;
            end
            want = pending_replies.pop_front();
            if (got.block_number !== want.block_number)
            begin
                $error("block_number: expected %0d, got %0d", want.block_number,
                       got.block_number);
                errors++;
            end
            if (got.status !== want.status)
            begin
                $error("status: expected %0d, got %0d", want.status, got.status);
                errors++;
            end
            if (got.last !== want.last)
            begin
                $error("last: expected %0d, got %0d", want.last, got.last);
                errors++;
            end
            if (got.occupied !== want.occupied)
            begin
                $error("occupied: expected %0d, got %0d", want.occupied, got.occupied);
                errors++;
            end
        endfunction
    endclass

    logic              clk = 1'b0;
    logic              rst_n;
    logic              start;
    bba_pkg::request_t request;
    logic              busy;
    logic              result_valid;
    bba_pkg::result_t  result;

    alloc_scoreboard sb = new();
    int              cycles = 0;

    block_bitmap_allocator #(
        .NUM_BLOCKS      (NUM_BLOCKS),
        .RESERVED_BLOCKS (RESERVED_BLOCKS),
        .MAX_RUN         (MAX_RUN)
    ) dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .request      (request),
        .busy         (busy),
        .result_valid (result_valid),
        .result       (result)
    );

    always #5 clk = ~clk;

    always @(posedge clk)
    begin
        cycles++;
        if (cycles >= CYCLE_LIMIT)
        begin
            $display("FAILURE");
            $finish;
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && result_valid)
            sb.check_result(result);
    end

    function automatic bba_pkg::request_t make_req(logic m, int cnt, int addr);
        bba_pkg::request_t r;
        r.mode       = m;
        r.count      = cnt[6:0];
        r.block_addr = addr[13:0];
        return r;
    endfunction

    // Optionally idle, then hold the request until it is taken.
    task automatic send_request(input bba_pkg::request_t r, input int idle_pct);
        int gap;
        if (idle_pct > 0 && $urandom_range(0, 99) < idle_pct)
        begin
            gap = ($urandom_range(0, 1) == 1) ? $urandom_range(1, 3) : $urandom_range(4, 90);
            start <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        start   <= 1'b1;
        request <= r;
        do
            @(posedge clk);
        while (busy !== 1'b0);
        sb.note_request(r);
    endtask

    initial
    begin
        bba_pkg::request_t r;
        int                idle_pct;
        int                pick;

        rst_n   = 1'b0;
        start   = 1'b0;
        request = '0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;

        // directed corners
        send_request(make_req(MODE_ALLOC, 1, 0), 37);
        send_request(make_req(MODE_ALLOC, MAX_RUN, 0), 37);
        send_request(make_req(MODE_ALLOC, 0, 16383), 37);
        send_request(make_req(MODE_ALLOC, MAX_RUN + 1, 0), 37);
        send_request(make_req(MODE_ALLOC, 127, 5), 37);
        send_request(make_req(MODE_FREE, 0, 0), 37);
        send_request(make_req(MODE_FREE, 5, RESERVED_BLOCKS - 1), 37);
        send_request(make_req(MODE_FREE, 0, RESERVED_BLOCKS), 37);
        send_request(make_req(MODE_FREE, 0, RESERVED_BLOCKS), 37);
        send_request(make_req(MODE_FREE, 127, 16383), 37);
        send_request(make_req(MODE_FREE, 64, 100), 37);
        send_request(make_req(MODE_FREE, 1, 127), 37);
        send_request(make_req(MODE_ALLOC, 3, 16383), 37);
        send_request(make_req(MODE_ALLOC, 2, 8191), 37);
        send_request(make_req(MODE_FREE, 0, 8192), 37);
        send_request(make_req(MODE_ALLOC, 33, 0), 37);
        send_request(make_req(MODE_FREE, 0, 130), 37);
        send_request(make_req(MODE_ALLOC, 1, 0), 37);

        // random mix: sender idles 37%, then 62%, then not at all
        for (int i = 0; i < 70; i++)
        begin
            idle_pct     = (i < 20) ? 37 : (i < 44) ? 62 : 0;
            r.count      = 7'($urandom_range(0, 127));
            r.block_addr = 14'($urandom_range(0, 16383));
            if ($urandom_range(0, 99) < 55)
            begin
                r.mode = MODE_ALLOC;
                pick = $urandom_range(0, 99);
                if (pick < 80)
                    r.count = 7'($urandom_range(1, 16));
                else if (pick < 90)
                    r.count = 7'($urandom_range(17, MAX_RUN));
                else if (pick < 95)
                    r.count = 7'd0;
                else
                    r.count = 7'($urandom_range(MAX_RUN + 1, 127));
            end
            else
            begin
                r.mode = MODE_FREE;
                pick = $urandom_range(0, 99);
                // mostly hit blocks handed out so far; the rest lands on reserved or anywhere
                if (pick < 75)
                    r.block_addr = 14'($urandom_range(RESERVED_BLOCKS, sb.top_block));
                else if (pick < 85)
                    r.block_addr = 14'($urandom_range(0, RESERVED_BLOCKS - 1));
            end
            send_request(r, idle_pct);
        end

        // free at the top edge and scattered, then rescan the holes
        send_request(make_req(MODE_ALLOC, 1, 0), 0);
        send_request(make_req(MODE_FREE, 0, 16383), 0);
        send_request(make_req(MODE_FREE, 0, 16383), 0);
        send_request(make_req(MODE_ALLOC, 1, 0), 0);
        for (int i = 0; i < 6; i++)
            send_request(make_req(MODE_FREE, 0,
                         $urandom_range(RESERVED_BLOCKS, sb.top_block)), 0);
        send_request(make_req(MODE_ALLOC, 8, 0), 0);
        send_request(make_req(MODE_ALLOC, $urandom_range(1, 6), 0), 0);

        start <= 1'b0;
        while (sb.pending_replies.size() > 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (sb.errors == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule

>>> sim.f
rtl/bba_pkg.sv
rtl/bba_map_mem.sv
rtl/bba_first_zero.sv
rtl/bba_ctrl.sv
rtl/block_bitmap_allocator.sv
tb/tb_block_bitmap_allocator.sv
